// ===== rtl/lrupr_pkg.sv =====
package lrupr_pkg;

    // Default sizes of the frame set and of a page number.
    localparam int FRAME_COUNT_DEF = 8;
    localparam int PAGE_BITS_DEF   = 20;

    // Fixed field widths of the register and result ports.
    localparam int CFG_BITS         = 4;
    localparam int FRAME_INDEX_BITS = 3;
    localparam int FAULT_BITS       = 32;
    localparam int APB_DATA_BITS    = 32;
    localparam int APB_ADDR_BITS    = 3;

    localparam logic [CFG_BITS-1:0]   FRAMES_IN_USE_RESET = 4'd8;
    localparam logic [FAULT_BITS-1:0] FAULT_MAX           = '1;

    // Register index, taken from the word address bit of paddr.
    typedef enum logic {
        REG_FRAMES_IN_USE = 1'b0
    } t_reg_index;

    // Sequencer of the replacement engine.
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_UPDATE
    } t_back_state;

endpackage

// ===== rtl/lrupr_front.sv =====
module lrupr_front
    import lrupr_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [PAGE_BITS-1:0] i_page,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic [PAGE_BITS-1:0] o_page
);

    // Two-entry queue that decouples request acceptance from the engine.
    logic [PAGE_BITS-1:0] r_mem [2];
    logic                 r_wr_ptr;
    logic                 r_rd_ptr;
    logic [1:0]           r_count;
    logic                 wr_en;
    logic                 rd_en;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_page  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_page;
        end
    end

endmodule

// ===== rtl/lrupr_back.sv =====
module lrupr_back
    import lrupr_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    parameter int PAGE_BITS   = PAGE_BITS_DEF,
    parameter int CW          = $clog2(FRAME_COUNT + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [CW-1:0]               i_count,
    input  logic                        i_q_empty,
    input  logic [PAGE_BITS-1:0]        i_q_page,
    output logic                        o_q_pop,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic                        o_hit,
    output logic [FRAME_INDEX_BITS-1:0] o_frame_index,
    output logic                        o_evicted_valid,
    output logic [PAGE_BITS-1:0]        o_evicted_page,
    output logic [FAULT_BITS-1:0]       o_fault_count
);

    localparam int IW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam logic [IW-1:0] RANK_MAX = IW'(FRAME_COUNT - 1);

    t_back_state r_state, n_state;

    logic [PAGE_BITS-1:0]  r_page;
    logic [PAGE_BITS-1:0]  r_frame_page [FRAME_COUNT];
    logic [FRAME_COUNT-1:0] r_valid, n_valid;
    logic [IW-1:0]         r_rank [FRAME_COUNT];
    logic [IW-1:0]         n_rank [FRAME_COUNT];
    logic [FAULT_BITS-1:0] r_fault, n_fault;

    // Decision taken in the lookup cycle.
    logic                 r_hit;
    logic                 r_evict;
    logic [IW-1:0]        r_sel;
    logic [PAGE_BITS-1:0] r_old_page;

    logic                 r_out_valid;
    logic                 r_out_hit;
    logic [IW-1:0]        r_out_frame;
    logic                 r_out_evict;
    logic [PAGE_BITS-1:0] r_out_page;
    logic [FAULT_BITS-1:0] r_out_fault;

    logic [FRAME_COUNT-1:0] in_use;
    logic                   look_hit;
    logic [IW-1:0]          hit_idx;
    logic                   look_empty;
    logic [IW-1:0]          empty_idx;
    logic [IW-1:0]          victim_idx;
    logic [FRAME_COUNT-1:0] is_max;
    logic [IW-1:0]          look_sel;
    logic                   commit;
    logic                   out_free;
    logic [IW+2:0]          frame_ext;

    assign out_free = !r_out_valid || i_pop;

    always_comb begin
        for (int i = 0; i < FRAME_COUNT; i++) begin
            in_use[i] = (CW'(i) < i_count);
        end
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (out_free) begin
                    n_state = i_q_empty ? S_IDLE : S_LOOK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        commit  = 1'b0;
        o_q_pop = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_q_pop = !i_q_empty;
            end
            S_LOOK: begin
                o_q_pop = 1'b0;
            end
            S_UPDATE: begin
                commit  = out_free;
                o_q_pop = out_free && !i_q_empty;
            end
            default: begin
                commit  = 1'b0;
                o_q_pop = 1'b0;
            end
        endcase
    end

    // Lookup: tag match, first empty frame and least recently used frame.
    always_comb begin
        look_hit   = 1'b0;
        hit_idx    = '0;
        look_empty = 1'b0;
        empty_idx  = '0;
        victim_idx = '0;
        for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
            if (r_valid[i] && in_use[i] && (r_frame_page[i] == r_page)) begin
                look_hit = 1'b1;
                hit_idx  = IW'(i);
            end
            if (in_use[i] && !r_valid[i]) begin
                look_empty = 1'b1;
                empty_idx  = IW'(i);
            end
        end
        for (int i = 0; i < FRAME_COUNT; i++) begin
            is_max[i] = in_use[i];
            for (int j = 0; j < FRAME_COUNT; j++) begin
                if (in_use[j] && (r_rank[j] > r_rank[i])) begin
                    is_max[i] = 1'b0;
                end
            end
        end
        for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
            if (is_max[i]) begin
                victim_idx = IW'(i);
            end
        end
        if (look_hit) begin
            look_sel = hit_idx;
        end else if (look_empty) begin
            look_sel = empty_idx;
        end else begin
            look_sel = victim_idx;
        end
    end

    // Commit: recency update, frame fill and fault count.
    always_comb begin
        n_valid = r_valid & in_use;
        n_fault = r_fault;
        for (int i = 0; i < FRAME_COUNT; i++) begin
            n_rank[i] = r_rank[i];
        end
        if (commit) begin
            for (int i = 0; i < FRAME_COUNT; i++) begin
                if ((IW'(i) != r_sel) && r_valid[i]
                        && (!(r_hit || r_evict) || (r_rank[i] < r_rank[r_sel]))
                        && (r_rank[i] < RANK_MAX)) begin
                    n_rank[i] = r_rank[i] + IW'(1);
                end
            end
            n_rank[r_sel]  = '0;
            n_valid[r_sel] = 1'b1;
            if (!r_hit && (r_fault != FAULT_MAX)) begin
                n_fault = r_fault + FAULT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_fault     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < FRAME_COUNT; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_fault <= n_fault;
            for (int i = 0; i < FRAME_COUNT; i++) begin
                r_rank[i] <= n_rank[i];
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_page <= i_q_page;
        end
        if (r_state == S_LOOK) begin
            r_hit      <= look_hit;
            r_evict    <= !look_hit && !look_empty;
            r_sel      <= look_sel;
            r_old_page <= r_frame_page[victim_idx];
        end
        if (commit) begin
            r_frame_page[r_sel] <= r_page;
            r_out_hit   <= r_hit;
            r_out_frame <= r_sel;
            r_out_evict <= r_evict;
            r_out_page  <= r_evict ? r_old_page : '0;
            r_out_fault <= n_fault;
        end
    end

    assign frame_ext       = {3'b000, r_out_frame};
    assign o_empty         = !r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_frame_index   = frame_ext[FRAME_INDEX_BITS-1:0];
    assign o_evicted_valid = r_out_evict;
    assign o_evicted_page  = r_out_page;
    assign o_fault_count   = r_out_fault;

endmodule

// ===== rtl/lru_page_replacement.sv =====
// A reference passes through the queue, the engine's lookup step and its update step;
// the update waits while the previous result has not been popped.
// The queue takes new references while the engine works on an earlier one.
// Reset is synchronous and active low: all frames empty, ranks and fault count zero,
// frames_in_use back to 8. No clearing pass is needed; references are taken at once.
module lru_page_replacement
    import lrupr_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    parameter int PAGE_BITS   = PAGE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Reference queue side.
    input  logic                        push,
    output logic                        full,
    input  logic [PAGE_BITS-1:0]        i_page_number,
    // Result queue side.
    output logic                        empty,
    input  logic                        pop,
    output logic                        o_hit,
    output logic [FRAME_INDEX_BITS-1:0] o_frame_index,
    output logic                        o_evicted_valid,
    output logic [PAGE_BITS-1:0]        o_evicted_page,
    output logic [FAULT_BITS-1:0]       o_fault_count,
    // Register port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [APB_ADDR_BITS-1:0]    paddr,
    input  logic [APB_DATA_BITS-1:0]    pwdata,
    output logic [APB_DATA_BITS-1:0]    prdata,
    output logic                        pready
);

    // Width of an effective frame count, which runs from 1 to FRAME_COUNT.
    localparam int CW   = $clog2(FRAME_COUNT + 1);
    localparam int CMPW = (CW > CFG_BITS) ? CW : CFG_BITS;

    logic [CFG_BITS-1:0]  r_frames_in_use;
    logic [CMPW-1:0]      cfg_ext;
    logic [CW-1:0]        eff_count;
    logic                 cfg_write;
    logic                 q_empty;
    logic                 q_pop;
    logic [PAGE_BITS-1:0] q_page;

    // The register port never stalls. A write lands in its access cycle; the
    // register sits at byte address zero and other addresses read as zero.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= FRAMES_IN_USE_RESET;
        end else if (cfg_write && (paddr[1:0] == 2'b00)) begin
            unique case (paddr[2])
                REG_FRAMES_IN_USE: r_frames_in_use <= pwdata[CFG_BITS-1:0];
                default: r_frames_in_use <= r_frames_in_use;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (paddr[2])
                REG_FRAMES_IN_USE: prdata = APB_DATA_BITS'(r_frames_in_use);
                default: prdata = '0;
            endcase
        end
    end

    // A written count of zero behaves as one frame, and a count above the
    // frame array behaves as the whole array. The engine drops the valid bit
    // of every frame outside this count in the cycle after a write, so a
    // shrunk frame set comes back empty when it grows again.
    always_comb begin
        cfg_ext = CMPW'(r_frames_in_use);
        if (cfg_ext == '0) begin
            eff_count = CW'(1);
        end else if (cfg_ext > CMPW'(FRAME_COUNT)) begin
            eff_count = CW'(FRAME_COUNT);
        end else begin
            eff_count = CW'(cfg_ext);
        end
    end

    // Front: a short queue holds references while the engine is busy, so the
    // requester sees full only when two references are already waiting.
    lrupr_front #(
        .PAGE_BITS (PAGE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_page  (i_page_number),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_page  (q_page)
    );

    // Back: the replacement engine looks up a reference in its lookup state (tag
    // compare, first empty frame, least recently used frame) and commits it
    // in its update state once its output register is free. A finished result waits
    // there while the next reference is already being looked up.
    lrupr_back #(
        .FRAME_COUNT (FRAME_COUNT),
        .PAGE_BITS   (PAGE_BITS),
        .CW          (CW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_count         (eff_count),
        .i_q_empty       (q_empty),
        .i_q_page        (q_page),
        .o_q_pop         (q_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_hit           (o_hit),
        .o_frame_index   (o_frame_index),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_count   (o_fault_count)
    );

endmodule
